FILE: hw/rtl/sbcs_pkg.sv
// shared types and constants for the servo bus command scheduler
`default_nettype none
package sbcs_pkg;
  localparam int unsigned SCAN_LIMIT = 254;
  localparam int unsigned NUM_SLOTS = 256;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    OP_SET_MODE = 3'd0, OP_SET_POS = 3'd1, OP_SET_MAXVEL = 3'd2, OP_SET_VEL = 3'd3,
    OP_DISABLE = 3'd4, OP_ENABLE = 3'd5, OP_SERVICE = 3'd6, OP_READ_REPLY = 3'd7
  } op_t;

  localparam logic [2:0] CMD_READ = 3'd0;
  localparam logic [2:0] CMD_SET_POS = 3'd1;
  localparam logic [2:0] CMD_SET_MODE = 3'd2;
  localparam logic [2:0] CMD_SET_VEL = 3'd3;
  localparam logic [2:0] CMD_DISABLE = 3'd4;

  localparam logic [1:0] ST_UNMANAGED = 2'd0;
  localparam logic [1:0] ST_ENABLING = 2'd1;
  localparam logic [1:0] ST_DISABLING = 2'd2;
  localparam logic [1:0] ST_ON = 2'd3;

  localparam logic [1:0] CM_POSITION = 2'd0;
  localparam logic [1:0] CM_VELOCITY = 2'd1;

  localparam logic [0:0] REG_SERVOS_DISABLED = 1'd0;
  localparam logic [0:0] REG_RESEND_PERIOD = 1'd1;
  localparam logic [3:0] RESEND_RESET = 4'd10;

  // one classified request passed from front to back
  typedef struct packed {
    op_t         op;
    logic [7:0]  servo_id;
    logic [1:0]  control_mode;
    logic [15:0] value;
    logic        read_ok;
  } req_t;
endpackage
`default_nettype wire

FILE: hw/rtl/sbcs_front.sv
// front end: takes requests, drops no-op ones, queues the rest
`default_nettype none
module sbcs_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [2:0]    mode,
  input  wire logic [7:0]    servo_id,
  input  wire logic [1:0]    control_mode,
  input  wire logic [15:0]   value,
  input  wire logic          read_ok,
  input  wire logic          servos_disabled,
  output sbcs_pkg::req_t     req,
  output logic               req_valid,
  input  wire logic          req_take
);
  localparam int unsigned AW = $clog2(sbcs_pkg::QUEUE_DEPTH);
  sbcs_pkg::req_t q [sbcs_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic acc, keep;

  assign busy = (cnt == (AW+1)'(sbcs_pkg::QUEUE_DEPTH));
  assign acc = start && !busy;
  // service and read reply do nothing while servos are disabled
  assign keep = !(servos_disabled && (mode == sbcs_pkg::OP_SERVICE ||
                                      mode == sbcs_pkg::OP_READ_REPLY));
  assign req_valid = (cnt != '0);
  assign req = q[rp];

  // queue storage and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (acc && keep) begin
        q[wp] <= '{op: sbcs_pkg::op_t'(mode), servo_id: servo_id,
                   control_mode: control_mode, value: value, read_ok: read_ok};
        wp <= wp + 1'b1;
      end
      if (req_take) rp <= rp + 1'b1;
      cnt <= cnt + (AW+1)'(acc && keep) - (AW+1)'(req_take);
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/sbcs_back.sv
// back end: slot table, scan and bus command emission
`default_nettype none
module sbcs_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sbcs_pkg::req_t req,
  input  wire logic          req_valid,
  output logic               req_take,
  input  wire logic [3:0]    resend_period,
  output logic               strobe,
  output logic [7:0]         target_servo,
  output logic [2:0]         command,
  output logic [15:0]        command_value,
  output logic [1:0]         command_mode,
  output logic               last
);
  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_PRIME, S_SCAN, S_DO, S_EMIT} state_t;

  // one slot table entry
  typedef struct packed {
    logic [1:0]  state;
    logic [1:0]  mode;
    logic [15:0] target;
    logic [15:0] maxvel;
    logic        init;
    logic [3:0]  count;
  } slot_t;

  state_t st;
  slot_t slot_mem [sbcs_pkg::NUM_SLOTS];
  slot_t rd, sl, upd, mem_wd;
  logic mem_we;
  logic [7:0] mem_wa, ptr, daddr, scan, clr;
  sbcs_pkg::req_t cur;
  logic [1:0] n_cmd, idx, n_new;
  logic [2:0] cmds [4];
  logic [15:0] vals [4];
  logic [1:0] cms [4];
  logic [2:0] new_cmd [4];
  logic [15:0] new_val [4];
  logic [1:0] new_cm [4];
  logic [3:0] cnt_dec, cnt_new;

  assign req_take = (st == S_IDLE) && req_valid;

  // slot table: one write port, registered read at ptr
  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[mem_wa] <= mem_wd;
    rd <= slot_mem[ptr];
    daddr <= ptr;
  end

  // resend counter tick, enabling slots start from the period
  always_comb begin
    cnt_dec = ((sl.state == sbcs_pkg::ST_ENABLING) ? resend_period : sl.count) - 4'd1;
    cnt_new = (cnt_dec == 4'd0) ? resend_period : cnt_dec;
  end

  // updated slot entry and the bus commands for the current request
  always_comb begin
    upd = sl;
    n_new = 2'd0;
    for (int j = 0; j < 4; j++) begin
      new_cmd[j] = sbcs_pkg::CMD_READ;
      new_val[j] = '0;
      new_cm[j] = '0;
    end
    case (cur.op)
      sbcs_pkg::OP_SET_MODE: begin
        upd.state = sbcs_pkg::ST_ENABLING;
        upd.mode = cur.control_mode;
        upd.init = 1'b1;
      end
      sbcs_pkg::OP_SET_POS: begin
        upd.target = cur.value;
        upd.init = 1'b0;
      end
      sbcs_pkg::OP_SET_MAXVEL: upd.maxvel = cur.value;
      sbcs_pkg::OP_SET_VEL: upd.target = cur.value;
      sbcs_pkg::OP_DISABLE: upd.state = sbcs_pkg::ST_DISABLING;
      sbcs_pkg::OP_ENABLE: upd.state = sbcs_pkg::ST_ENABLING;
      sbcs_pkg::OP_READ_REPLY: begin
        if (cur.read_ok) begin
          new_cmd[0] = sbcs_pkg::CMD_SET_POS;
          new_val[0] = cur.value;
          new_cmd[1] = sbcs_pkg::CMD_SET_MODE;
          new_cm[1] = sbcs_pkg::CM_POSITION;
          n_new = 2'd2;
          if (sl.init) begin
            upd.init = 1'b0;
            upd.target = cur.value;
          end
        end else begin
          upd.state = sbcs_pkg::ST_ENABLING;
        end
      end
      default: begin
        // service of the slot found by the scan
        case (sl.state)
          sbcs_pkg::ST_ENABLING: begin
            upd.state = sbcs_pkg::ST_ON;
            upd.count = cnt_new;
            if (sl.mode == sbcs_pkg::CM_POSITION) begin
              new_cmd[0] = sbcs_pkg::CMD_READ;
              n_new = 2'd1;
            end
          end
          sbcs_pkg::ST_DISABLING: begin
            upd.state = sbcs_pkg::ST_UNMANAGED;
            new_cmd[0] = sbcs_pkg::CMD_DISABLE;
            n_new = 2'd1;
          end
          sbcs_pkg::ST_ON: begin
            upd.count = cnt_new;
            // optional mode resend, then targets
            if (sl.count == 4'd1) begin
              new_cmd[n_new] = sbcs_pkg::CMD_SET_MODE;
              new_cm[n_new] = sl.mode;
              n_new = n_new + 2'd1;
            end
            if (sl.mode == sbcs_pkg::CM_VELOCITY) begin
              new_cmd[n_new] = sbcs_pkg::CMD_SET_VEL;
              new_val[n_new] = sl.target;
              n_new = n_new + 2'd1;
            end else if (sl.mode == sbcs_pkg::CM_POSITION) begin
              new_cmd[n_new] = sbcs_pkg::CMD_SET_POS;
              new_val[n_new] = sl.target;
              n_new = n_new + 2'd1;
              if (sl.maxvel != 16'd0 && !sl.maxvel[15]) begin
                new_cmd[n_new] = sbcs_pkg::CMD_SET_VEL;
                new_val[n_new] = sl.maxvel;
                n_new = n_new + 2'd1;
              end
            end
          end
          default: ;
        endcase
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_CLEAR;
      clr <= '0;
      scan <= '0;
      mem_we <= 1'b0;
      strobe <= 1'b0;
      last <= 1'b0;
    end else begin
      strobe <= 1'b0;
      last <= 1'b0;
      mem_we <= 1'b0;
      case (st)
        S_CLEAR: begin
          // empty the slot table once after reset
          mem_we <= 1'b1;
          mem_wa <= clr;
          mem_wd <= '0;
          clr <= clr + 8'd1;
          if (clr == 8'hFF) st <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) begin
            cur <= req;
            if (req.op == sbcs_pkg::OP_SERVICE) ptr <= scan;
            else ptr <= req.servo_id;
            st <= S_PRIME;
          end
        end
        S_PRIME: begin
          // scan keeps the read address one slot ahead of the data
          if (cur.op == sbcs_pkg::OP_SERVICE) ptr <= ptr + 8'd1;
          st <= S_SCAN;
        end
        S_SCAN: begin
          if (cur.op != sbcs_pkg::OP_SERVICE) begin
            sl <= rd;
            st <= S_DO;
          end else if (daddr >= 8'(sbcs_pkg::SCAN_LIMIT)) begin
            scan <= '0;
            st <= S_IDLE;
          end else if (rd.state == sbcs_pkg::ST_UNMANAGED) begin
            ptr <= ptr + 8'd1;
          end else begin
            sl <= rd;
            ptr <= daddr;
            st <= S_DO;
          end
        end
        S_DO: begin
          mem_we <= 1'b1;
          mem_wa <= ptr;
          mem_wd <= upd;
          if (cur.op == sbcs_pkg::OP_SERVICE)
            scan <= (ptr == 8'(sbcs_pkg::SCAN_LIMIT - 1)) ? 8'd0 : ptr + 8'd1;
          for (int j = 0; j < 4; j++) begin
            cmds[j] <= new_cmd[j];
            vals[j] <= new_val[j];
            cms[j] <= new_cm[j];
          end
          n_cmd <= n_new;
          idx <= '0;
          st <= (n_new != 2'd0) ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          strobe <= 1'b1;
          target_servo <= ptr;
          command <= cmds[idx];
          command_value <= vals[idx];
          command_mode <= cms[idx];
          last <= (idx + 2'd1 == n_cmd);
          idx <= idx + 2'd1;
          if (idx + 2'd1 == n_cmd) st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/servo_bus_command_scheduler.sv
// servo bus command scheduler: top level with configuration registers
// host request: the slot engine steps through take, read wait, load and update
// read reply: those steps, then one emit step per command
// service: those steps, with the scan stepping past each unmanaged slot, then one emit step per command
// requests queue four deep ahead of the engine; busy only when full; receiver cannot stall
// sync reset clears the configuration, then a pass over all 256 slots empties the slot table
`default_nettype none
module servo_bus_command_scheduler (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  mode,
  input  wire logic [7:0]  servo_id,
  input  wire logic [1:0]  control_mode,
  input  wire logic [15:0] value,
  input  wire logic        read_ok,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [3:0]  cfg_data,
  output logic             strobe,
  output logic [7:0]       target_servo,
  output logic [2:0]       command,
  output logic [15:0]      command_value,
  output logic [1:0]       command_mode,
  output logic             last
);
  logic servos_disabled;
  logic [3:0] resend_period;
  sbcs_pkg::req_t req;
  logic req_valid, req_take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      servos_disabled <= 1'b0;
      resend_period <= sbcs_pkg::RESEND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sbcs_pkg::REG_SERVOS_DISABLED: servos_disabled <= cfg_data[0];
        sbcs_pkg::REG_RESEND_PERIOD:
          resend_period <= (cfg_data == 4'd0) ? 4'd1 : cfg_data;
        default: ;
      endcase
    end
  end

  sbcs_front u_front (
    .clk, .rst, .start, .busy, .mode, .servo_id, .control_mode, .value, .read_ok,
    .servos_disabled, .req, .req_valid, .req_take
  );

  sbcs_back u_back (
    .clk, .rst, .req, .req_valid, .req_take, .resend_period, .strobe,
    .target_servo, .command, .command_value, .command_mode, .last
  );
endmodule
`default_nettype wire
